/* rtl/nucleotide_bit_packer_unit_macros.svh */
// ----------------------------------------------------------------------------
// nucleotide bit packer assertion macros
// shared concurrent assertion forms, clocked on i_clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef NUCLEOTIDE_BIT_PACKER_UNIT_MACROS_SVH
`define NUCLEOTIDE_BIT_PACKER_UNIT_MACROS_SVH

// same-cycle implication
`define NBP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nbp assertion failed");

// next-cycle implication
`define NBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nbp assertion failed");

`endif

/* rtl/nbp_pkg.sv */
// ----------------------------------------------------------------------------
// nbp_pkg
// shared word types and constants of the nucleotide bit packer
// ----------------------------------------------------------------------------
package nbp_pkg;

    // kind codes of an input word
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // code_mode values
    localparam logic MODE_3BIT = 1'b0;
    localparam logic MODE_4BIT = 1'b1;

    // output queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;

    typedef struct packed {
        logic       kind;
        logic [7:0] symbol;
    } t_in_word;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_byte;
    } t_out_word;

    // packer to output queue
    typedef struct packed {
        logic      push0;
        logic      push1;
        t_out_word word0;
        t_out_word word1;
    } t_pack_res;

endpackage

/* rtl/nbp_encoder.sv */
// ----------------------------------------------------------------------------
// nbp_encoder
// maps a character or an end marker to a bit field in stream order
// ----------------------------------------------------------------------------
module nbp_encoder (
    input  logic             i_mode,
    input  nbp_pkg::t_in_word i_word,
    output logic [3:0]       o_field,
    output logic [2:0]       o_width
);

    logic [3:0] code;
    logic [3:0] digit;

    // ascii digits sit at 0x30..0x39, so the low nibble is the digit value
    assign digit = i_word.symbol[3:0];

    always_comb begin
        code    = 4'd0;
        o_width = 3'd0;
        if (i_word.kind == nbp_pkg::KIND_END) begin
            // terminator: 1,1,0 or 0,0,0,0
            if (i_mode == nbp_pkg::MODE_3BIT) begin
                code    = 4'd6;
                o_width = 3'd3;
            end else begin
                code    = 4'd0;
                o_width = 3'd4;
            end
        end else if (i_mode == nbp_pkg::MODE_3BIT) begin
            o_width = 3'd3;
            case (i_word.symbol)
                8'h41:   code = 4'd0;
                8'h43:   code = 4'd1;
                8'h47:   code = 4'd2;
                8'h54:   code = 4'd3;
                8'h4E:   code = 4'd4;
                8'h24:   code = 4'd5;
                default: o_width = 3'd0;
            endcase
        end else begin
            o_width = 3'd4;
            case (i_word.symbol)
                8'h41:   code = 4'd1;
                8'h43:   code = 4'd2;
                8'h47:   code = 4'd3;
                8'h54:   code = 4'd4;
                8'h4E:   code = 4'd5;
                default: begin
                    if (i_word.symbol >= 8'h30 && i_word.symbol <= 8'h39) begin
                        code = digit + 4'd6;
                    end else begin
                        o_width = 3'd0;
                    end
                end
            endcase
        end
    end

    // msb of the code goes first, so it lands at field bit 0
    always_comb begin
        if (o_width == 3'd4) begin
            o_field = {code[0], code[1], code[2], code[3]};
        end else begin
            o_field = {1'b0, code[0], code[1], code[2]};
        end
    end

endmodule

/* rtl/nbp_packer.sv */
// ----------------------------------------------------------------------------
// nbp_packer
// holds the pending bits and turns one coded word into up to two bytes
// ----------------------------------------------------------------------------
module nbp_packer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_mode,
    input  nbp_pkg::t_in_word i_word,
    output nbp_pkg::t_pack_res o_res,
    output logic [2:0]        o_pend_cnt
);

    logic [6:0]  r_pend_bits;
    logic [2:0]  r_pend_cnt;
    logic [6:0]  n_pend_bits;
    logic [2:0]  n_pend_cnt;
    logic [3:0]  field;
    logic [2:0]  width;
    logic [10:0] acc;
    logic [3:0]  sum_cnt;

    nbp_encoder u_enc (
        .i_mode  (i_mode),
        .i_word  (i_word),
        .o_field (field),
        .o_width (width)
    );

    assign acc     = {4'd0, r_pend_bits} | ({7'd0, field} << r_pend_cnt);
    assign sum_cnt = {1'b0, r_pend_cnt} + {1'b0, width};

    always_comb begin
        o_res                   = '0;
        o_res.word0.packed_byte = acc[7:0];
        o_res.word1.packed_byte = {5'd0, acc[10:8]};
        o_res.word1.last_byte   = 1'b1;
        n_pend_bits             = r_pend_bits;
        n_pend_cnt              = r_pend_cnt;
        if (i_fire) begin
            if (i_word.kind == nbp_pkg::KIND_END) begin
                o_res.push0 = 1'b1;
                if (sum_cnt > 4'd8) begin
                    // spill: full byte then padded last byte
                    o_res.push1 = 1'b1;
                end else begin
                    o_res.word0.last_byte = 1'b1;
                end
                n_pend_bits = 7'd0;
                n_pend_cnt  = 3'd0;
            end else if (sum_cnt >= 4'd8) begin
                o_res.push0 = 1'b1;
                n_pend_bits = {4'd0, acc[10:8]};
                n_pend_cnt  = sum_cnt[2:0];
            end else begin
                n_pend_bits = acc[6:0];
                n_pend_cnt  = sum_cnt[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= 7'd0;
            r_pend_cnt  <= 3'd0;
        end else begin
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

    assign o_pend_cnt = r_pend_cnt;

endmodule

/* rtl/nbp_out_fifo.sv */
// ----------------------------------------------------------------------------
// nbp_out_fifo
// small result queue, takes up to two words a cycle and gives one
// ----------------------------------------------------------------------------
module nbp_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nbp_pkg::t_pack_res i_res,
    input  logic               i_pop,
    output logic               o_valid,
    output nbp_pkg::t_out_word o_word,
    output logic [2:0]         o_count
);

    nbp_pkg::t_out_word r_mem [nbp_pkg::FIFO_DEPTH];

    logic [nbp_pkg::FIFO_AW-1:0] r_wr_ptr;
    logic [nbp_pkg::FIFO_AW-1:0] r_rd_ptr;
    logic [2:0]                  r_count;
    logic [nbp_pkg::FIFO_AW-1:0] n_wr_ptr;
    logic [nbp_pkg::FIFO_AW-1:0] n_rd_ptr;
    logic [2:0]                  n_count;
    logic [2:0]                  push_n;
    logic                        pop_ok;
    logic [nbp_pkg::FIFO_AW-1:0] wr_ptr1;

    assign pop_ok  = i_pop && (r_count != 3'd0);
    assign push_n  = {2'd0, i_res.push0} + {2'd0, i_res.push1};
    assign wr_ptr1 = r_wr_ptr + {{(nbp_pkg::FIFO_AW-1){1'b0}}, 1'b1};

    always_comb begin
        n_wr_ptr = r_wr_ptr + push_n[nbp_pkg::FIFO_AW-1:0];
        n_rd_ptr = r_rd_ptr + {{(nbp_pkg::FIFO_AW-1){1'b0}}, pop_ok};
        n_count  = r_count + push_n - {2'd0, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (i_res.push0) begin
            r_mem[r_wr_ptr] <= i_res.word0;
        end
        if (i_res.push1) begin
            r_mem[wr_ptr1] <= i_res.word1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_valid = (r_count != 3'd0);
    assign o_word  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

/* rtl/nucleotide_bit_packer_unit.sv */
// ----------------------------------------------------------------------------
// nucleotide_bit_packer_unit
// packs sequence characters into bytes with a three- or four-bit code
// ----------------------------------------------------------------------------
// one input word is taken every cycle while the result queue has room; a word
// is registered in the input stage, coded and packed when two queue slots are
// free, and its bytes go into the result queue, which drives the output.
// a character gives zero or one byte, an end word one or two, so the sustained
// rate of one word per cycle is set by the single-byte-per-cycle output port;
// only an end word whose terminator spills past a byte boundary gives a second
// byte, absorbed by the four-entry result queue. code_mode is sampled when a
// word is packed and must only be written while the unit is idle.
module nucleotide_bit_packer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  nbp_pkg::t_in_word  i_in_word,
    // packed bytes
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output nbp_pkg::t_out_word o_out_word,
    // code_mode register
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);

    // mode register, reset to four-bit alphabet
    logic              r_mode;

    // input register stage
    logic              r_in_valid;
    nbp_pkg::t_in_word r_in_word;
    logic              in_take;

    // pack stage control
    logic              pack_fire;
    nbp_pkg::t_pack_res pack_res;
    logic [2:0]        pend_cnt;
    logic [2:0]        fifo_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= nbp_pkg::MODE_4BIT;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // pack a staged word only when two queue slots are sure to be free
    assign pack_fire  = r_in_valid && (fifo_count <= 3'(nbp_pkg::FIFO_DEPTH - 2));
    // stage drains or is empty: take a new word the same cycle
    assign o_in_ready = !r_in_valid || pack_fire;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    nbp_packer u_packer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (pack_fire),
        .i_mode     (r_mode),
        .i_word     (r_in_word),
        .o_res      (pack_res),
        .o_pend_cnt (pend_cnt)
    );

    nbp_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (pack_res),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .o_count (fifo_count)
    );

`include "nucleotide_bit_packer_unit_macros.svh"

    // an end word always leaves the packer empty
`NBP_ASSERT_NEXT(a_end_clears, pack_fire && (r_in_word.kind == nbp_pkg::KIND_END), pend_cnt == 3'd0)
    // queue never overfills
`NBP_ASSERT_SAME(a_fifo_bound, 1'b1, fifo_count <= 3'(nbp_pkg::FIFO_DEPTH))
    // a stalled staged word is not dropped
`NBP_ASSERT_NEXT(a_stage_hold, r_in_valid && !pack_fire, r_in_valid && $stable(r_in_word))

endmodule
